[rtl/core/swms_pkg.sv]
// ----------------------------------------------------------------------------
// Sliding window mean and standard deviation package
// Shared constants, command and status structures, and the controller states.
// ----------------------------------------------------------------------------
package swms_pkg;

    localparam int DEF_MAX_WINDOW  = 1024;
    localparam int DEF_SAMPLE_BITS = 16;
    localparam int CFG_W           = 11;
    localparam int OUT_W           = 24;
    localparam int LEN_RESET       = 64;
    localparam int LEN_MIN         = 2;
    localparam int FRAC_BITS       = 8;
    localparam int SQRT_FRAC_BITS  = 16;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_READ,
        ST_SQUARE,
        ST_UPDATE,
        ST_PRODUCT,
        ST_PREP,
        ST_ITER,
        ST_DIV2,
        ST_DIV2_RUN,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic in_ready;
        logic read;
        logic square;
        logic update;
        logic product;
        logic prep;
        logic iter;
        logic div2_start;
        logic div2_step;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic emit;
        logic iter_done;
        logic div_done;
        logic out_free;
    } t_status;

endpackage

[rtl/core/swms_if.sv]
// ----------------------------------------------------------------------------
// Stream interfaces
// Sample channel and result channel, each with valid, ready and payload.
// ----------------------------------------------------------------------------
interface swms_in_if #(
    parameter int SAMPLE_BITS = swms_pkg::DEF_SAMPLE_BITS
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          new_series;

    modport source (output valid, output sample, output new_series, input ready);
    modport sink   (input valid, input sample, input new_series, output ready);
endinterface

interface swms_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [swms_pkg::OUT_W-1:0]   mean;
    logic        [swms_pkg::OUT_W-1:0]   std_dev;
    logic        [swms_pkg::OUT_W-1:0]   window_index;

    modport source (output valid, output mean, output std_dev, output window_index,
                    input ready);
    modport sink   (input valid, input mean, input std_dev, input window_index,
                    output ready);
endinterface

[rtl/core/swms_div.sv]
// ----------------------------------------------------------------------------
// Restoring divider
// Produces one quotient bit per step; the remainder is discarded.
// ----------------------------------------------------------------------------
module swms_div #(
    parameter int DW = 35,
    parameter int VW = 11
) (
    input  logic          i_clk,
    input  logic          i_start,
    input  logic          i_step,
    input  logic [DW-1:0] i_dividend,
    input  logic [VW-1:0] i_divisor,
    output logic [DW-1:0] o_quotient,
    output logic          o_done
);
    localparam int CW = $clog2(DW + 1);

    logic [VW-1:0] r_rem;
    logic [DW-1:0] r_quo;
    logic [CW-1:0] r_cnt;
    logic [VW:0]   trial;

    assign trial      = {r_rem, r_quo[DW-1]};
    assign o_done     = (r_cnt == CW'(DW));
    assign o_quotient = r_quo;

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_cnt <= '0;
        end else if (i_step && !o_done) begin
            r_cnt <= r_cnt + 1'b1;
            if (trial >= {1'b0, i_divisor}) begin
                r_rem <= VW'(trial - {1'b0, i_divisor});
                r_quo <= {r_quo[DW-2:0], 1'b1};
            end else begin
                r_rem <= trial[VW-1:0];
                r_quo <= {r_quo[DW-2:0], 1'b0};
            end
        end
    end
endmodule

[rtl/core/swms_sqrt.sv]
// ----------------------------------------------------------------------------
// Integer square root
// Digit-by-digit root, one radicand bit pair per step, floor result.
// ----------------------------------------------------------------------------
module swms_sqrt #(
    parameter int RW = 70
) (
    input  logic            i_clk,
    input  logic            i_start,
    input  logic            i_step,
    input  logic [RW-1:0]   i_radicand,
    output logic [RW/2-1:0] o_root,
    output logic            o_done
);
    localparam int QW = RW / 2;
    localparam int MW = QW + 3;
    localparam int CW = $clog2(QW + 1);

    logic [RW-1:0] r_rad;
    logic [QW-1:0] r_root;
    logic [MW-1:0] r_rem;
    logic [CW-1:0] r_cnt;
    logic [MW-1:0] shifted;
    logic [MW-1:0] trial;

    assign shifted = {r_rem[MW-3:0], r_rad[RW-1:RW-2]};
    assign trial   = MW'({r_root, 2'b01});
    assign o_root  = r_root;
    assign o_done  = (r_cnt == CW'(QW));

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rad  <= i_radicand;
            r_root <= '0;
            r_rem  <= '0;
            r_cnt  <= '0;
        end else if (i_step && !o_done) begin
            r_cnt <= r_cnt + 1'b1;
            r_rad <= {r_rad[RW-3:0], 2'b00};
            if (shifted >= trial) begin
                r_rem  <= shifted - trial;
                r_root <= {r_root[QW-2:0], 1'b1};
            end else begin
                r_rem  <= shifted;
                r_root <= {r_root[QW-2:0], 1'b0};
            end
        end
    end
endmodule

[rtl/core/swms_ctrl.sv]
// ----------------------------------------------------------------------------
// Sliding window controller
// Sequences the update, product, root and division steps of one sample.
// ----------------------------------------------------------------------------
module swms_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  swms_pkg::t_status i_status,
    output swms_pkg::t_cmd    o_cmd
);
    import swms_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                o_cmd.in_ready = 1'b1;
                if (i_in_valid) n_state = ST_READ;
            end
            ST_READ: begin
                o_cmd.read = 1'b1;
                n_state    = ST_SQUARE;
            end
            ST_SQUARE: begin
                o_cmd.square = 1'b1;
                n_state      = ST_UPDATE;
            end
            ST_UPDATE: begin
                o_cmd.update = 1'b1;
                n_state      = i_status.emit ? ST_PRODUCT : ST_IDLE;
            end
            ST_PRODUCT: begin
                o_cmd.product = 1'b1;
                n_state       = ST_PREP;
            end
            ST_PREP: begin
                o_cmd.prep = 1'b1;
                n_state    = ST_ITER;
            end
            ST_ITER: begin
                o_cmd.iter = 1'b1;
                if (i_status.iter_done) n_state = ST_DIV2;
            end
            ST_DIV2: begin
                o_cmd.div2_start = 1'b1;
                n_state          = ST_DIV2_RUN;
            end
            ST_DIV2_RUN: begin
                o_cmd.div2_step = 1'b1;
                if (i_status.div_done) n_state = ST_FINISH;
            end
            ST_FINISH: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end
endmodule

[rtl/core/swms_dp.sv]
// ----------------------------------------------------------------------------
// Sliding window datapath
// Delay line, exact running sums, products, root and divider, result register.
// ----------------------------------------------------------------------------
module swms_dp #(
    parameter int MAX_WINDOW  = swms_pkg::DEF_MAX_WINDOW,
    parameter int SAMPLE_BITS = swms_pkg::DEF_SAMPLE_BITS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [swms_pkg::CFG_W-1:0]   i_cfg_wdata,
    input  swms_pkg::t_cmd               i_cmd,
    output swms_pkg::t_status            o_status,
    swms_in_if.sink                      i_in,
    swms_out_if.source                   o_out
);
    import swms_pkg::*;

    localparam int SB     = SAMPLE_BITS;
    localparam int PW     = (MAX_WINDOW > 2) ? $clog2(MAX_WINDOW) : 1;
    localparam int LW     = $clog2(MAX_WINDOW + 1);
    localparam int IW     = LW + 1;
    localparam int SUM_W  = SB + PW + 1;
    localparam int SQ_W   = 2 * SB + PW;
    localparam int NUM_W  = LW + SQ_W;
    localparam int RAD_W  = ((NUM_W + SQRT_FRAC_BITS + 1) / 2) * 2;
    localparam int ROOT_W = RAD_W / 2;
    localparam int MEAN_W = SUM_W + FRAC_BITS;
    localparam int DW     = (MEAN_W > ROOT_W) ? MEAN_W : ROOT_W;
    localparam int EXT_W  = (DW > OUT_W) ? DW : OUT_W;

    logic [SB-1:0]            mem [MAX_WINDOW];
    logic [CFG_W-1:0]         r_len;
    logic signed [SB-1:0]     r_x;
    logic signed [SB-1:0]     r_old;
    logic [2*SB-1:0]          r_xsq;
    logic [2*SB-1:0]          r_osq;
    logic                     r_slide;
    logic signed [SUM_W-1:0]  r_sum;
    logic [SQ_W-1:0]          r_sq;
    logic [LW-1:0]            r_fill;
    logic [PW-1:0]            r_wp;
    logic [OUT_W-1:0]         r_cnt;
    logic [NUM_W-1:0]         r_mp;
    logic [NUM_W-1:0]         r_ss;
    logic [SUM_W-1:0]         r_smag;
    logic                     r_neg;
    logic [DW-1:0]            r_mean_q;
    logic                     r_ovalid;
    logic signed [OUT_W-1:0]  r_omean;
    logic [OUT_W-1:0]         r_osd;
    logic [OUT_W-1:0]         r_oidx;

    logic [LW-1:0]            m_act;
    logic [IW-1:0]            wp_ext;
    logic [IW-1:0]            m_ext;
    logic [PW-1:0]            old_idx;
    logic signed [2*SB-1:0]   xsq_c;
    logic signed [2*SB-1:0]   osq_c;
    logic [SUM_W-1:0]         smag_c;
    logic [NUM_W-1:0]         mp_c;
    logic [2*SUM_W-1:0]       ss_c;
    logic [NUM_W-1:0]         num_c;
    logic                     load;
    logic                     div_start;
    logic                     div_step;
    logic [DW-1:0]            div_dividend;
    logic [DW-1:0]            div_q;
    logic                     div_done;
    logic [ROOT_W-1:0]        root;
    logic                     sqrt_done;
    logic [EXT_W-1:0]         q_ext;
    logic [EXT_W-1:0]         mean_ext;

    always_comb begin
        if (32'(r_len) < LEN_MIN) begin
            m_act = LW'(LEN_MIN);
        end else if (32'(r_len) > MAX_WINDOW) begin
            m_act = LW'(MAX_WINDOW);
        end else begin
            m_act = LW'(r_len);
        end
    end

    assign wp_ext  = IW'(r_wp);
    assign m_ext   = IW'(m_act);
    assign old_idx = (wp_ext >= m_ext) ? PW'(wp_ext - m_ext)
                                       : PW'(wp_ext + IW'(MAX_WINDOW) - m_ext);

    assign xsq_c  = r_x * r_x;
    assign osq_c  = r_old * r_old;
    assign smag_c = r_sum[SUM_W-1] ? SUM_W'(-r_sum) : SUM_W'(r_sum);
    assign mp_c   = m_act * r_sq;
    assign ss_c   = smag_c * smag_c;
    assign num_c  = r_mp - r_ss;

    assign load       = i_in.valid && i_in.ready;
    assign i_in.ready = i_cmd.in_ready;

    assign div_start    = i_cmd.prep || i_cmd.div2_start;
    assign div_step     = i_cmd.iter || i_cmd.div2_step;
    assign div_dividend = i_cmd.prep ? DW'({r_smag, FRAC_BITS'(0)}) : DW'(root);

    swms_div #(
        .DW (DW),
        .VW (LW)
    ) u_div (
        .i_clk      (i_clk),
        .i_start    (div_start),
        .i_step     (div_step),
        .i_dividend (div_dividend),
        .i_divisor  (m_act),
        .o_quotient (div_q),
        .o_done     (div_done)
    );

    swms_sqrt #(
        .RW (RAD_W)
    ) u_sqrt (
        .i_clk      (i_clk),
        .i_start    (i_cmd.prep),
        .i_step     (i_cmd.iter),
        .i_radicand (RAD_W'({num_c, SQRT_FRAC_BITS'(0)})),
        .o_root     (root),
        .o_done     (sqrt_done)
    );

    assign o_status.emit      = r_slide || ((r_fill + 1'b1) == m_act);
    assign o_status.iter_done = div_done && sqrt_done;
    assign o_status.div_done  = div_done;
    assign o_status.out_free  = !r_ovalid || o_out.ready;

    assign q_ext    = EXT_W'(r_mean_q);
    assign mean_ext = r_neg ? (~q_ext + 1'b1) : q_ext;

    always_ff @(posedge i_clk) begin
        if (i_cmd.read) begin
            r_old <= mem[old_idx];
        end
        if (i_cmd.update) begin
            mem[r_wp] <= r_x;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_x <= i_in.sample;
        end
        if (i_cmd.read) begin
            r_slide <= (r_fill >= m_act);
        end
        if (i_cmd.square) begin
            r_xsq <= xsq_c;
            r_osq <= osq_c;
        end
        if (i_cmd.product) begin
            r_mp   <= mp_c;
            r_ss   <= NUM_W'(ss_c);
            r_smag <= smag_c;
            r_neg  <= r_sum[SUM_W-1];
        end
        if (i_cmd.div2_start) begin
            r_mean_q <= div_q;
        end
        if (i_cmd.out_load) begin
            r_omean <= mean_ext[OUT_W-1:0];
            r_osd   <= OUT_W'(div_q);
            r_oidx  <= r_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len    <= CFG_W'(LEN_RESET);
            r_sum    <= '0;
            r_sq     <= '0;
            r_fill   <= '0;
            r_wp     <= '0;
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_len  <= i_cfg_wdata;
                r_sum  <= '0;
                r_sq   <= '0;
                r_fill <= '0;
                r_wp   <= '0;
                r_cnt  <= '0;
            end else if (load && i_in.new_series) begin
                r_sum  <= '0;
                r_sq   <= '0;
                r_fill <= '0;
                r_wp   <= '0;
                r_cnt  <= '0;
            end else if (i_cmd.update) begin
                r_sum <= r_sum + SUM_W'(r_x) - (r_slide ? SUM_W'(r_old) : SUM_W'(0));
                r_sq  <= r_sq + SQ_W'(r_xsq) - (r_slide ? SQ_W'(r_osq) : SQ_W'(0));
                if (!r_slide) r_fill <= r_fill + 1'b1;
                r_wp <= (r_wp == PW'(MAX_WINDOW - 1)) ? '0 : r_wp + 1'b1;
            end else if (i_cmd.out_load) begin
                r_cnt <= r_cnt + 1'b1;
            end
            if (i_cmd.out_load) begin
                r_ovalid <= 1'b1;
            end else if (o_out.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    assign o_out.valid        = r_ovalid;
    assign o_out.mean         = r_omean;
    assign o_out.std_dev      = r_osd;
    assign o_out.window_index = r_oidx;

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= m_act)
        else $error("fill count exceeds the window length");

    a_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> (!r_ovalid || o_out.ready))
        else $error("result register overwritten before its transaction");

    a_div_reuse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div2_start |-> (div_done && sqrt_done))
        else $error("divider restarted before the mean quotient was ready");

    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.update |=> !i_cmd.update)
        else $error("two delay line updates in consecutive cycles");
endmodule

[rtl/core/sliding_window_mean_std.sv]
// ----------------------------------------------------------------------------
// Sliding window mean and standard deviation
// Exact running sums over a delay line; Q8 mean and population deviation.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake      Payload
//  i_in      input      valid/ready    sample, new_series
//  o_out     output     valid/ready    mean, std_dev, window_index
//  i_cfg     input      write enable   window_length
//
//  A sample that yields a result uses the shared restoring divider twice:
//  once beside the square root and then again for the root over the window
//  length. Reset is synchronous; the delay line needs no clearing. A waiting
//  result only holds the last step.
module sliding_window_mean_std #(
    parameter int MAX_WINDOW  = swms_pkg::DEF_MAX_WINDOW,
    parameter int SAMPLE_BITS = swms_pkg::DEF_SAMPLE_BITS
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [swms_pkg::CFG_W-1:0] i_cfg_wdata,
    swms_in_if.sink                    i_in,
    swms_out_if.source                 o_out
);
    import swms_pkg::*;

    t_cmd    cmd;
    t_status status;

    swms_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    swms_dp #(
        .MAX_WINDOW  (MAX_WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_in        (i_in),
        .o_out       (o_out)
    );
endmodule

[tb/sv/tb_sliding_window_mean_std.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Sliding window mean and standard deviation testbench
// Streams sample transactions through the block under several window lengths
// and compares every result with a predictor that keeps exact integer sums.
// ----------------------------------------------------------------------------
class swms_scoreboard;
    typedef struct {
        logic [23:0] mean;
        logic [23:0] std_dev;
        logic [23:0] window_index;
    } t_stat;

    shortint        samples_seen[1024];
    longint         win_sum;
    longint         win_sq_sum;
    int             filled;
    int             wr_ptr;
    int             win_count;
    int             win_len;
    t_stat          pending_stats[$];
    int             errors;

    function new();
        win_len = 64;
        errors = 0;
        restart();
    endfunction

    function void restart();
        win_sum = 0;
        win_sq_sum = 0;
        filled = 0;
        wr_ptr = 0;
        win_count = 0;
    endfunction

    function void set_length(int value);
        win_len = value;
        restart();
    endfunction

    function longint unsigned root_scaled(longint unsigned a);
        longint unsigned root;
        longint unsigned rem;
        longint unsigned trial;
        longint unsigned pair;
        root = 0;
        rem = 0;
        for (int i = 0; i < 40; i++) begin
            pair = (i < 32) ? ((a >> (62 - 2 * i)) & 3) : 0;
            rem = (rem << 2) | pair;
            trial = (root << 2) | 1;
            if (rem >= trial) begin
                rem -= trial;
                root = (root << 1) | 1;
            end else begin
                root = root << 1;
            end
        end
        return root;
    endfunction

    function void push_stat(int m);
        t_stat           s;
        longint unsigned mag;
        longint unsigned q;
        longint unsigned num;
        mag = (win_sum < 0) ? -win_sum : win_sum;
        q = (mag << 8) / m;
        s.mean = (win_sum < 0) ? 24'(-q) : 24'(q);
        num = longint'(m) * win_sq_sum - mag * mag;
        s.std_dev = 24'(root_scaled(num) / m);
        s.window_index = 24'(win_count);
        win_count = (win_count + 1) & 24'hFFFFFF;
        pending_stats.push_back(s);
    endfunction

    function void note_sample(logic signed [15:0] x, logic fresh);
        int     m;
        longint old;
        m = (win_len < 2) ? 2 : (win_len > 1024 ? 1024 : win_len);
        if (fresh) restart();
        if (filled < m) begin
            samples_seen[wr_ptr] = x;
            win_sum += x;
            win_sq_sum += longint'(x) * x;
            filled++;
            wr_ptr = (wr_ptr + 1) % 1024;
            if (filled == m) push_stat(m);
        end else begin
            old = samples_seen[(wr_ptr + 1024 - m) % 1024];
            win_sum += x - old;
            win_sq_sum += longint'(x) * x - old * old;
            samples_seen[wr_ptr] = x;
            wr_ptr = (wr_ptr + 1) % 1024;
            push_stat(m);
        end
    endfunction

    function void check_stat(logic [23:0] mean, logic [23:0] sd, logic [23:0] idx);
        t_stat e;
        if (pending_stats.size() == 0) begin
            $display("%0t: unexpected result mean=%h std=%h idx=%h", $time, mean, sd, idx);
            errors++;
            return;
        end
        e = pending_stats.pop_front();
        if (mean !== e.mean) begin
            $display("%0t: mean expected %h actual %h", $time, e.mean, mean);
            errors++;
        end
        if (sd !== e.std_dev) begin
            $display("%0t: std_dev expected %h actual %h", $time, e.std_dev, sd);
            errors++;
        end
        if (idx !== e.window_index) begin
            $display("%0t: window_index expected %h actual %h", $time, e.window_index, idx);
            errors++;
        end
    endfunction
endclass

module tb_sliding_window_mean_std;
    import swms_pkg::*;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_cfg_we;
    logic [CFG_W-1:0]    i_cfg_wdata;
    logic                rx_hold;
    logic                stall_long;
    int                  cycles;
    swms_scoreboard      stats;

    swms_in_if  in_ch ();
    swms_out_if out_ch ();

    sliding_window_mean_std i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (in_ch.sink),
        .o_out       (out_ch.source)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (in_ch.valid && in_ch.ready) stats.note_sample(in_ch.sample, in_ch.new_series);
        if (out_ch.valid && out_ch.ready)
            stats.check_stat(out_ch.mean, out_ch.std_dev, out_ch.window_index);
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 3000000) begin
            $display("** sliding_window_mean_std: FAILED **");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (stall_long) out_ch.ready <= 1'b0;
        else if (rx_hold) out_ch.ready <= ($urandom_range(0, 3) != 0);
        else out_ch.ready <= 1'b1;
    end

    initial begin
        rx_hold = 1'b0;
        forever begin
            repeat ($urandom_range(50, 400)) @(posedge i_clk);
            rx_hold <= ~rx_hold;
        end
    end

    task automatic send_sample(logic signed [15:0] x, logic fresh);
        in_ch.valid <= 1'b1;
        in_ch.sample <= x;
        in_ch.new_series <= fresh;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
    endtask

    task automatic pause_sender();
        in_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 120)) @(posedge i_clk);
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (stats.pending_stats.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    task automatic write_length(int value);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= value[CFG_W-1:0];
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        stats.set_length(value);
        @(posedge i_clk);
    endtask

    task automatic random_run(int count, int heavy);
        int burst;
        burst = 0;
        for (int i = 0; i < count; i++) begin
            logic signed [15:0] x;
            case ($urandom_range(0, 3))
                0: x = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
                default: x = 16'($urandom);
            endcase
            if (heavy) x = $urandom_range(0, 1) ? 16'sh7FFF - 16'($urandom_range(0, 3))
                                                 : 16'sh8000 + 16'($urandom_range(0, 3));
            send_sample(x, ($urandom_range(0, 299) == 0));
            if (burst == 0) begin
                if ($urandom_range(0, 2) == 0) pause_sender();
                burst = $urandom_range(1, 40);
            end else begin
                burst--;
            end
        end
    endtask

    initial begin
        stats = new();
        cycles = 0;
        stall_long = 1'b0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = '0;
        in_ch.valid = 1'b0;
        in_ch.sample = '0;
        in_ch.new_series = 1'b0;
        out_ch.ready = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset length of 64, with extremes and a series restart.
        for (int i = 0; i < 70; i++) send_sample(i[0] ? 16'sh7FFF : 16'sh8000, i == 66);
        drain();

        write_length(2);
        send_sample(16'sh8000, 1'b0);
        send_sample(16'sh8000, 1'b0);
        send_sample(16'sh7FFF, 1'b0);
        send_sample(16'sh0000, 1'b0);
        send_sample(-16'sd1, 1'b0);
        send_sample(16'sh0001, 1'b1);
        send_sample(-16'sd3, 1'b0);
        send_sample(16'sh5555, 1'b0);
        drain();

        write_length(0);
        random_run(150, 0);
        drain();

        write_length(2047);
        random_run(300, 0);
        drain();

        write_length(1024);
        random_run(1100, 1);
        drain();

        write_length(3);
        fork
            begin
                stall_long <= 1'b1;
                repeat (600) @(posedge i_clk);
                stall_long <= 1'b0;
            end
            random_run(100, 0);
        join
        drain();

        write_length(17);
        random_run(200, 0);
        drain();

        if (stats.errors == 0) begin
            $display("** sliding_window_mean_std: PASSED **");
        end else begin
            $display("** sliding_window_mean_std: FAILED **");
        end
        $finish;
    end
endmodule
